// ----- rtl/acpu_pkg.sv -----
`timescale 1ns / 1ps

package acpu_pkg;

   // item kinds on the request channel
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_EXEC  = 1'b1;

   // instruction operation codes; codes above OP_SKIPZ act as no-op
   localparam logic [3:0] OP_NOP   = 4'd0;
   localparam logic [3:0] OP_LOAD  = 4'd1;
   localparam logic [3:0] OP_ADD   = 4'd2;
   localparam logic [3:0] OP_STORE = 4'd3;
   localparam logic [3:0] OP_SUB   = 4'd4;
   localparam logic [3:0] OP_INPUT = 4'd5;
   localparam logic [3:0] OP_OUT   = 4'd6;
   localparam logic [3:0] OP_HALT  = 4'd7;
   localparam logic [3:0] OP_JUMP  = 4'd8;
   localparam logic [3:0] OP_SKIPZ = 4'd9;

   // instruction word layout
   localparam int OP_W   = 4;
   localparam int OPD_W  = 4;
   localparam int WORD_W = OP_W + OPD_W;
   localparam int ACC_W  = 32;

   // outcome of one executed instruction
   typedef struct packed {
      logic [ACC_W-1:0] acc;
      logic             store;
      logic             show;
      logic             halt;
      logic             jump;
      logic             skip;
   } exec_type;

endpackage

// ----- rtl/acpu_alu.sv -----
`timescale 1ns / 1ps

module acpu_alu (
   input  logic [acpu_pkg::OP_W-1:0]  op,
   input  logic [acpu_pkg::ACC_W-1:0] acc,
   input  logic [acpu_pkg::ACC_W-1:0] data_value,
   input  logic [acpu_pkg::ACC_W-1:0] in_value,
   output acpu_pkg::exec_type         result
);

   // decode the operation and form the new accumulator and control flags
   always_comb begin
      result       = '0;
      result.acc   = acc;
      case (op)
         acpu_pkg::OP_LOAD:  result.acc   = data_value;
         acpu_pkg::OP_ADD:   result.acc   = acc + data_value;
         acpu_pkg::OP_STORE: result.store = 1'b1;
         acpu_pkg::OP_SUB:   result.acc   = acc - data_value;
         acpu_pkg::OP_INPUT: result.acc   = in_value;
         acpu_pkg::OP_OUT:   result.show  = 1'b1;
         acpu_pkg::OP_HALT:  result.halt  = 1'b1;
         acpu_pkg::OP_JUMP:  result.jump  = 1'b1;
         acpu_pkg::OP_SKIPZ: result.skip  = (acc == '0);
         default:            result.acc   = acc;
      endcase
   end

endmodule

// ----- rtl/accumulator_cpu_step.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Transfer marker        Payload
// request   in         start & !busy          req_opcode, req_prog_addr, req_instr_op,
//                                             req_instr_operand, req_in_value
// response  out        rsp_strobe (1 cycle)   rsp_pc, rsp_acc, rsp_out_valid, rsp_halted
//
// A program word write, or an execute while halted, answers in the cycle after the
// transfer and the next request may come in that same cycle.
// An executed instruction goes through program memory read, data memory read,
// then update and write back; busy stays high until the result strobe.
// After reset a clearing pass zeroes both memories, with busy high throughout.
// The receiver cannot stall; each result is shown for exactly one cycle.
module accumulator_cpu_step #(
   parameter int PROG_WORDS = 128,
   parameter int DATA_WORDS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [6:0]  req_prog_addr,
   input  logic [3:0]  req_instr_op,
   input  logic [3:0]  req_instr_operand,
   input  logic signed [31:0] req_in_value,
   output logic        rsp_strobe,
   output logic [6:0]  rsp_pc,
   output logic signed [31:0] rsp_acc,
   output logic        rsp_out_valid,
   output logic        rsp_halted
);

   localparam int PA_W = $clog2(PROG_WORDS);
   localparam int DA_W = $clog2(DATA_WORDS);
   localparam logic [10:0]   PROG_LIMIT = 11'(PROG_WORDS);
   localparam logic [10:0]   DATA_LIMIT = 11'(DATA_WORDS);
   localparam logic [PA_W-1:0] PC_LAST  = PA_W'(PROG_WORDS - 1);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_FETCH = 4'b0100,
      ST_EXEC  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [PA_W-1:0] clear_idx_ff, clear_idx_in;
   logic [PA_W-1:0] pc_ff, pc_in;
   logic [acpu_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic halted_ff, halted_in;
   logic strobe_ff, strobe_in;
   logic out_valid_ff, out_valid_in;
   logic [acpu_pkg::ACC_W-1:0] inval_ff;

   logic [acpu_pkg::WORD_W-1:0] prog_mem [PROG_WORDS];
   logic [acpu_pkg::WORD_W-1:0] prog_rdata_ff;
   logic [acpu_pkg::ACC_W-1:0]  data_mem [DATA_WORDS];
   logic [acpu_pkg::ACC_W-1:0]  data_rdata_ff;

   logic                        accept;
   logic [10:0]                 paddr_wide;
   logic                        paddr_ok;
   logic                        prog_we;
   logic [PA_W-1:0]             prog_waddr;
   logic [acpu_pkg::WORD_W-1:0] prog_wdata;
   logic [acpu_pkg::OP_W-1:0]   word_op;
   logic [acpu_pkg::OPD_W-1:0]  word_opd;
   logic [10:0]                 opd_wide;
   logic                        opd_ok;
   logic [DA_W-1:0]             opd_idx;
   logic                        clear_data;
   logic                        data_we;
   logic [DA_W-1:0]             data_waddr;
   logic [acpu_pkg::ACC_W-1:0]  data_wdata;
   logic [acpu_pkg::ACC_W-1:0]  data_value;
   logic [PA_W-1:0]             pc_inc;
   logic [PA_W-1:0]             pc_skip;
   logic [PA_W-1:0]             pc_jump;
   logic [10:0]                 pc_wide;
   acpu_pkg::exec_type          ex;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // program word write port: clearing pass or a word-write transfer
   assign paddr_wide = {4'b0, req_prog_addr};
   assign paddr_ok   = (paddr_wide < PROG_LIMIT);
   assign prog_we    = (state_ff == ST_CLEAR)
                    || (accept && (req_opcode == acpu_pkg::REQ_WRITE) && paddr_ok);
   assign prog_waddr = (state_ff == ST_CLEAR) ? clear_idx_ff : paddr_wide[PA_W-1:0];
   assign prog_wdata = (state_ff == ST_CLEAR) ? '0 : {req_instr_op, req_instr_operand};

   // program memory, read at the current pc
   always_ff @(posedge clock) begin
      if (prog_we) begin
         prog_mem[prog_waddr] <= prog_wdata;
      end
      prog_rdata_ff <= prog_mem[pc_ff];
   end

   // split the fetched word; out-of-range operands read as zero
   assign word_op  = prog_rdata_ff[acpu_pkg::WORD_W-1:acpu_pkg::OPD_W];
   assign word_opd = prog_rdata_ff[acpu_pkg::OPD_W-1:0];
   assign opd_wide = {7'b0, word_opd};
   assign opd_ok   = (opd_wide < DATA_LIMIT);
   assign opd_idx  = opd_wide[DA_W-1:0];

   // data write port: clearing pass or a store in the execute cycle
   assign clear_data = (state_ff == ST_CLEAR) && ({{(11-PA_W){1'b0}}, clear_idx_ff} < DATA_LIMIT);
   assign data_we    = clear_data || ((state_ff == ST_EXEC) && ex.store && opd_ok);
   assign data_waddr = clear_data ? clear_idx_ff[DA_W-1:0] : opd_idx;
   assign data_wdata = clear_data ? '0 : acc_ff;

   // data memory, read at the fetched operand
   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[data_waddr] <= data_wdata;
      end
      data_rdata_ff <= data_mem[opd_idx];
   end

   assign data_value = opd_ok ? data_rdata_ff : '0;

   acpu_alu u_alu (
      .op         (word_op),
      .acc        (acc_ff),
      .data_value (data_value),
      .in_value   (inval_ff),
      .result     (ex)
   );

   // next pc candidates; increment and skip wrap at the program size
   assign pc_inc  = (pc_ff == PC_LAST) ? '0 : pc_ff + PA_W'(1);
   assign pc_skip = (pc_inc == PC_LAST) ? '0 : pc_inc + PA_W'(1);
   assign pc_jump = opd_wide[PA_W-1:0];

   // sequence the clear pass, fetch and execute
   always_comb begin
      state_in     = state_ff;
      clear_idx_in = clear_idx_ff;
      pc_in        = pc_ff;
      acc_in       = acc_ff;
      halted_in    = halted_ff;
      strobe_in    = 1'b0;
      out_valid_in = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clear_idx_in = clear_idx_ff + PA_W'(1);
            if (clear_idx_ff == PC_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if ((req_opcode == acpu_pkg::REQ_EXEC) && !halted_ff) begin
                  state_in = ST_FETCH;
               end else begin
                  strobe_in = 1'b1;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            strobe_in    = 1'b1;
            out_valid_in = ex.show;
            acc_in       = ex.acc;
            halted_in    = halted_ff || ex.halt;
            if (ex.jump) begin
               pc_in = pc_jump;
            end else if (ex.skip) begin
               pc_in = pc_skip;
            end else begin
               pc_in = pc_inc;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_idx_ff <= '0;
         pc_ff        <= '0;
         acc_ff       <= '0;
         halted_ff    <= 1'b0;
         strobe_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         pc_ff        <= pc_in;
         acc_ff       <= acc_in;
         halted_ff    <= halted_in;
         strobe_ff    <= strobe_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // hold the input value for the execute cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         inval_ff <= req_in_value;
      end
   end

   // drive the response straight from the architectural registers
   assign pc_wide       = {{(11-PA_W){1'b0}}, pc_ff};
   assign rsp_strobe    = strobe_ff;
   assign rsp_pc        = pc_wide[6:0];
   assign rsp_acc       = acc_ff;
   assign rsp_out_valid = out_valid_ff;
   assign rsp_halted    = halted_ff;

   a_onehot_state: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_EXEC) || $past(accept))
      else $error("result strobe without a transfer or an execute");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag dropped");

   a_store_window: assert property (@(posedge clock) disable iff (reset)
      data_we |-> (state_ff == ST_EXEC) || (state_ff == ST_CLEAR))
      else $error("data memory written outside execute or clear");

   a_out_valid_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_out_valid |-> rsp_strobe)
      else $error("output flag without a result strobe");

endmodule
